### rtl/ssg_pkg.sv
// -----------------------------------------------------------------------------
// ssg_pkg: shared types and constants of the sector signature block
// Command codes, register indexes, signature constants and size helpers.
// -----------------------------------------------------------------------------
package ssg_pkg;

	// operation codes on the input stream
	localparam logic [1:0] OP_GENERATE = 2'd0;
	localparam logic [1:0] OP_BEGIN    = 2'd1;
	localparam logic [1:0] OP_VERIFY   = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DISK_SERIAL  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LOG2  = 8'd1;
	localparam logic [3:0]           SECTOR_LOG2_RST  = 4'd9;
	localparam logic [3:0]           SECTOR_LOG2_MIN  = 4'd5;
	localparam logic [3:0]           SECTOR_LOG2_MAX  = 4'd9;
	localparam logic [3:0]           WORD_BYTES_LOG2  = 4'd3;

	// signature constants
	localparam logic [63:0] MAGIC_WORD   = 64'hADDE4BFA53575053;
	localparam logic [63:0] SEED_MIX     = 64'hDEADBEEFCAFEBABE;
	localparam logic [63:0] LCG_MUL      = 64'h5851F42D4C957F2D;
	localparam logic [63:0] LCG_INC      = 64'h14057B7EF767814F;
	localparam int unsigned SERIAL_SHIFT = 13;

	typedef enum logic [1:0] {
		CMD_GEN   = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [63:0] data;	// aligned offset, or read-back word for a check
	} cmd_t;

	function automatic logic [3:0] clamp_log2(input logic [3:0] lg);
		logic [3:0] r;
		r = lg;
		if (lg < SECTOR_LOG2_MIN) r = SECTOR_LOG2_MIN;
		if (lg > SECTOR_LOG2_MAX) r = SECTOR_LOG2_MAX;
		return r;
	endfunction

	function automatic logic [63:0] align_offset(input logic [63:0] off,
		input logic [3:0] lg);
		logic [3:0] l;
		l = clamp_log2(lg);
		return off & ({64{1'b1}} << l);
	endfunction

	function automatic logic [63:0] start_seed(input logic [63:0] off,
		input logic [63:0] serial);
		return off ^ (serial << SERIAL_SHIFT) ^ SEED_MIX;
	endfunction

endpackage

### rtl/ssg_front.sv
// -----------------------------------------------------------------------------
// ssg_front: input stage
// Takes stream words, aligns offsets, drops unused codes and queues commands.
// -----------------------------------------------------------------------------
module ssg_front import ssg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  sector_bytes_log2,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] offset_bytes,
	input  logic [63:0] read_word,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	localparam int unsigned DEPTH = 2;

	cmd_t       fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	cmd_t       cmd_new;
	logic       keep;
	logic       push;

	always_comb begin
		cmd_new.kind = CMD_GEN;
		cmd_new.data = align_offset(offset_bytes, sector_bytes_log2);
		keep         = 1'b1;
		case (operation)
			OP_GENERATE: begin
				cmd_new.kind = CMD_GEN;
			end
			OP_BEGIN: begin
				cmd_new.kind = CMD_BEGIN;
			end
			OP_VERIFY: begin
				cmd_new.kind = CMD_CHECK;
				cmd_new.data = read_word;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready  = (cnt_q != 2'(DEPTH));
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### rtl/ssg_back.sv
// -----------------------------------------------------------------------------
// ssg_back: execution stage
// Runs generate and verify commands on a shared LCG unit, owns the output word.
// -----------------------------------------------------------------------------
module ssg_back import ssg_pkg::*; #(
	parameter int unsigned MAX_SECTOR_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] disk_serial,
	input  logic [3:0]  sector_bytes_log2,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data,
	output logic [5:0]  out_index,
	output logic        out_last,
	output logic        out_is_verify,
	output logic        out_match
);

	localparam int unsigned IDX_W = $clog2(MAX_SECTOR_WORDS);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam logic [6:0]  MAX_W7 = 7'(MAX_SECTOR_WORDS);
	localparam logic [31:0] MUL_LO = LCG_MUL[31:0];
	localparam logic [31:0] MUL_HI = LCG_MUL[63:32];
	localparam logic [2:0]  BYTE_LAST = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WORD = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_DONE = 5'b10000
	} bk_state_t;

	bk_state_t        state_q;
	logic             chk_q;
	logic [63:0]      gseed_q;
	logic [63:0]      goff_q;
	logic [IDX_W-1:0] gidx_q;
	logic [63:0]      vseed_q;
	logic [63:0]      voff_q;
	logic [IDX_W-1:0] vidx_q;
	logic             vactive_q;
	logic             mism_q;
	logic [63:0]      rd_q;
	logic [63:0]      word_q;
	logic [2:0]       byte_q;
	logic [63:0]      plo_q;
	logic [31:0]      c1_q;
	logic [31:0]      c2_q;

	logic             out_valid_q;
	logic [63:0]      out_data_q;
	logic [5:0]       out_idx_q;
	logic             out_last_q;
	logic             out_isv_q;
	logic             out_match_q;

	logic [3:0]       lg;
	logic [6:0]       words_full;
	logic [6:0]       words_cap;
	logic [CNT_W-1:0] words;
	logic [IDX_W-1:0] cur_idx;
	logic [63:0]      cur_off;
	logic [63:0]      sel_seed;
	logic [63:0]      plo;
	logic [31:0]      c1;
	logic [31:0]      c2;
	logic [63:0]      new_seed;
	logic             is_last;
	logic             mism_next;
	logic             slot_free;
	logic             out_load;

	always_comb begin
		lg         = clamp_log2(sector_bytes_log2);
		words_full = 7'd1 << (lg - WORD_BYTES_LOG2);
		words_cap  = (words_full > MAX_W7) ? MAX_W7 : words_full;
		words      = words_cap[CNT_W-1:0];
	end

	assign cur_idx   = chk_q ? vidx_q : gidx_q;
	assign cur_off   = chk_q ? voff_q : goff_q;
	assign sel_seed  = chk_q ? vseed_q : gseed_q;
	assign is_last   = (CNT_W'(cur_idx) + CNT_W'(1)) >= words;
	assign mism_next = mism_q | (word_q != rd_q);
	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = (state_q == ST_DONE) && slot_free && (!chk_q || is_last);
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;

	// 64-bit modular product split into three 32x32 parts; the parts are registered before the add
	assign plo      = 64'(sel_seed[31:0]) * 64'(MUL_LO);
	assign c1       = sel_seed[63:32] * MUL_LO;
	assign c2       = sel_seed[31:0] * MUL_HI;
	assign new_seed = plo_q + {c1_q + c2_q, 32'b0} + LCG_INC;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			plo_q <= plo;
			c1_q  <= c1;
			c2_q  <= c2;
		end
		if (out_load) begin
			out_data_q  <= chk_q ? 64'd0 : word_q;
			out_idx_q   <= 6'(cur_idx);
			out_last_q  <= is_last;
			out_isv_q   <= chk_q;
			out_match_q <= chk_q && !mism_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			chk_q     <= 1'b0;
			gseed_q   <= '0;
			goff_q    <= '0;
			gidx_q    <= '0;
			vseed_q   <= '0;
			voff_q    <= '0;
			vidx_q    <= '0;
			vactive_q <= 1'b0;
			mism_q    <= 1'b0;
			rd_q      <= '0;
			word_q    <= '0;
			byte_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							CMD_GEN: begin
								chk_q   <= 1'b0;
								goff_q  <= cmd.data;
								gseed_q <= start_seed(cmd.data, disk_serial);
								gidx_q  <= '0;
								state_q <= ST_WORD;
							end
							CMD_BEGIN: begin
								voff_q    <= cmd.data;
								vseed_q   <= start_seed(cmd.data, disk_serial);
								vidx_q    <= '0;
								vactive_q <= 1'b1;
								mism_q    <= 1'b0;
							end
							CMD_CHECK: begin
								// no run open: the word is dropped
								if (vactive_q) begin
									chk_q   <= 1'b1;
									rd_q    <= cmd.data;
									state_q <= ST_WORD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WORD: begin
					byte_q <= '0;
					if (CNT_W'(cur_idx) == CNT_W'(0)) begin
						word_q  <= MAGIC_WORD;
						state_q <= ST_DONE;
					end else if (CNT_W'(cur_idx) == CNT_W'(1)) begin
						word_q  <= cur_off;
						state_q <= ST_DONE;
					end else if (CNT_W'(cur_idx) == CNT_W'(2)) begin
						word_q  <= disk_serial;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (chk_q) begin
						vseed_q <= new_seed;
					end else begin
						gseed_q <= new_seed;
					end
					// top byte of each step, lowest byte first
					word_q <= {new_seed[63:56], word_q[63:8]};
					byte_q <= byte_q + 3'd1;
					state_q <= (byte_q == BYTE_LAST) ? ST_DONE : ST_MUL;
				end
				ST_DONE: begin
					if (chk_q) begin
						if (!is_last) begin
							mism_q  <= mism_next;
							vidx_q  <= vidx_q + IDX_W'(1);
							state_q <= ST_IDLE;
						end else if (slot_free) begin
							mism_q    <= mism_next;
							vidx_q    <= '0;
							vactive_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end else if (slot_free) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							gidx_q  <= gidx_q + IDX_W'(1);
							state_q <= ST_WORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;
	assign out_index     = out_idx_q;
	assign out_last      = out_last_q;
	assign out_is_verify = out_isv_q;
	assign out_match     = out_match_q;

	a_verify_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_isv_q) |-> (out_last_q && out_data_q == 64'd0))
		else $error("verify result without last or with data");

	a_idle_run_parked: assert property (@(posedge clk) disable iff (!arst_n)
		!vactive_q |-> (vidx_q == '0))
		else $error("verify index left over with no run open");

	a_step_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |=> (state_q == ST_MUL || state_q == ST_DONE))
		else $error("LCG step left mid-word");

	a_gen_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && !chk_q) |-> (CNT_W'(gidx_q) < words))
		else $error("generate index beyond sector");

endmodule

### rtl/sector_signature_generate_verify.sv
// -----------------------------------------------------------------------------
// sector_signature_generate_verify: sector test signature generator/checker
// Config registers, input queue stage and execution stage with output word.
// -----------------------------------------------------------------------------
// A generate word (tuser 0) emits the whole sector, 4 to 64 words; begin
// verify (tuser 1) opens a check run and verify words (tuser 2) are compared
// in order, the last one returning a single result with the match flag. Words
// 0..2 (header, offset, serial) are loaded directly in the execution stage;
// every later word is built by the eight chained LCG steps, each of which
// first registers the 32x32 partial products and then does the add. Each
// command is taken from the queue in the idle state. A two-entry command
// queue lets new input words be taken while a sector is still being
// produced, and the output register holds a word while the next one is
// computed. Operation code 3 is dropped at the input.
module sector_signature_generate_verify import ssg_pkg::*; #(
	parameter int unsigned MAX_SECTOR_WORDS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [127:0]         s_tdata,	// offset_bytes[63:0], read_word[127:64]
	input  logic [1:0]           s_tuser,	// operation[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata,	// data_word[63:0], word_index[69:64], match[70], pad
	output logic                 m_tlast,
	output logic [0:0]           m_tuser	// is_verify[0]
);

	logic [63:0] serial_q;
	logic [3:0]  log2_q;
	logic        cmd_valid;
	cmd_t        cmd;
	logic        cmd_pop;
	logic [63:0] out_data;
	logic [5:0]  out_index;
	logic        out_is_verify;
	logic        out_match;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q <= '0;
			log2_q   <= SECTOR_LOG2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DISK_SERIAL: serial_q <= cfg_data;
				CFG_SECTOR_LOG2: log2_q   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	ssg_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.sector_bytes_log2 (log2_q),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.operation         (s_tuser),
		.offset_bytes      (s_tdata[63:0]),
		.read_word         (s_tdata[127:64]),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop)
	);

	ssg_back #(
		.MAX_SECTOR_WORDS (MAX_SECTOR_WORDS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.disk_serial       (serial_q),
		.sector_bytes_log2 (log2_q),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_data          (out_data),
		.out_index         (out_index),
		.out_last          (m_tlast),
		.out_is_verify     (out_is_verify),
		.out_match         (out_match)
	);

	assign m_tdata = {1'b0, out_match, out_index, out_data};
	assign m_tuser = out_is_verify;

endmodule
